### rtl/pcgbr_pkg.sv
// shared types, constants and helpers for the pcg32 bounded random generator
// no dependencies; used by every module of the block
package pcgbr_pkg;

	localparam int CMD_W = 3;
	localparam int WORD_W = 64;
	localparam int HALF_W = 32;
	localparam int DEF_QUEUE_DEPTH = 2;
	localparam int S_TDATA_W = 136;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CMD_W-1:0] CMD_RESEED = 3'd0;
	localparam logic [CMD_W-1:0] CMD_RAW32 = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RAW64 = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RANGE32 = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RANGE64 = 3'd4;

	localparam logic [CFG_INDEX_W-1:0] REG_SEED = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STREAM = 1'd1;

	localparam logic [WORD_W-1:0] LCG_MULT = 64'h5851_F42D_4C95_7F2D;
	// state after seeding with seed 0 and stream 0
	localparam logic [WORD_W-1:0] LCG_STATE_RST = 64'h5851_F42D_4C95_7F2E;
	localparam logic [WORD_W-1:0] LCG_INC_RST = 64'd1;

	typedef enum logic [2:0] {
		K_RESEED,
		K_RAW32,
		K_RAW64,
		K_RANGE32,
		K_RANGE64
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [WORD_W-1:0] lower;
		logic [WORD_W-1:0] span;
	} job_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LCG,
		S_DIV,
		S_OUT
	} back_st_t;

	// xsh-rr output permutation of the old state
	function automatic logic [HALF_W-1:0] permute(input logic [WORD_W-1:0] old);
		logic [WORD_W-1:0] x;
		logic [HALF_W-1:0] mixed;
		logic [4:0] rot;
		logic [2*HALF_W-1:0] dbl;
		x = ((old >> 18) ^ old) >> 27;
		mixed = x[HALF_W-1:0];
		rot = old[63:59];
		dbl = {mixed, mixed} >> rot;
		return dbl[HALF_W-1:0];
	endfunction

endpackage

### rtl/pcg32_bounded_random_generator_unit.sv
// pcg32 xsh-rr generator with raw and bounded draws, top level
// depends on pcgbr_pkg, pcgbr_front, pcgbr_queue and pcgbr_back
//
// Commands enter on the s_ side (reseed, raw32, raw64, range32, range64; codes 5-7 are
// taken and dropped) and wait in a short queue; results leave on the m_ side. Each draw
// forms the 64-bit lcg multiply from 32x32 partial products, one at a time on a single
// multiplier. A reseed takes 2 draws, raw32 one, raw64 two. A bounded request runs the
// bit-serial remainder unit once for the threshold and once for the result, over 32
// dividend bits for range32 and 64 for range64, plus one draw (or two for range64) per
// try; a zero span returns the lower bound without a draw. Seed and stream are written
// on the cfg_ port and take effect at the next reseed; the user must write them only
// while the block is idle, which the block itself does not enforce.
module pcg32_bounded_random_generator_unit #(
	parameter int QUEUE_DEPTH = pcgbr_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// command [2:0], lower_bound [66:3], upper_bound [130:67], zero fill above
	input  logic [pcgbr_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// random_value [63:0]
	output logic [pcgbr_pkg::WORD_W-1:0]      m_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              cfg_wen,
	input  logic [pcgbr_pkg::CFG_INDEX_W-1:0] cfg_addr,
	input  logic [pcgbr_pkg::WORD_W-1:0]      cfg_wdata
);
	import pcgbr_pkg::*;

	logic [WORD_W-1:0] seed_q, stream_q;
	logic q_not_full, q_not_empty, push, pop;
	job_t wr_job, rd_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			stream_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				REG_SEED: seed_q <= cfg_wdata;
				REG_STREAM: stream_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	pcgbr_front u_front (
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.q_ready  (q_not_full),
		.s_tready (s_tready),
		.push     (push),
		.job      (wr_job)
	);

	pcgbr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (wr_job),
		.not_full  (q_not_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.rd_job    (rd_job)
	);

	pcgbr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_not_empty),
		.job       (rd_job),
		.job_pop   (pop),
		.seed      (seed_q),
		.stream    (stream_q),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready)
	);

endmodule

### rtl/pcgbr_front.sv
// front end: decodes the command, drops unused codes and works out the span
// depends on pcgbr_pkg
module pcgbr_front (
	input  logic [pcgbr_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                            s_tvalid,
	input  logic                            q_ready,
	output logic                            s_tready,
	output logic                            push,
	output pcgbr_pkg::job_t                 job
);
	import pcgbr_pkg::*;

	logic [CMD_W-1:0] cmd;
	logic [WORD_W-1:0] lo;
	logic [WORD_W-1:0] hi;
	logic [WORD_W-1:0] diff;
	logic known;

	assign cmd = s_tdata[CMD_W-1:0];
	assign lo = s_tdata[CMD_W +: WORD_W];
	assign hi = s_tdata[CMD_W+WORD_W +: WORD_W];
	assign diff = hi - lo;
	assign s_tready = q_ready;

	always_comb begin
		known = 1'b1;
		job.kind = K_RESEED;
		job.lower = lo;
		job.span = diff;
		unique case (cmd)
			CMD_RESEED: job.kind = K_RESEED;
			CMD_RAW32: job.kind = K_RAW32;
			CMD_RAW64: job.kind = K_RAW64;
			CMD_RANGE32: begin
				job.kind = K_RANGE32;
				job.span = {{HALF_W{1'b0}}, diff[HALF_W-1:0]};
			end
			CMD_RANGE64: job.kind = K_RANGE64;
			default: known = 1'b0;
		endcase
	end

	// unused codes are taken and dropped
	assign push = s_tvalid && q_ready && known;

endmodule

### rtl/pcgbr_queue.sv
// short job queue between front and back end
// depends on pcgbr_pkg
module pcgbr_queue #(
	parameter int DEPTH = pcgbr_pkg::DEF_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pcgbr_pkg::job_t wr_job,
	output logic            not_full,
	input  logic            pop,
	output logic            not_empty,
	output pcgbr_pkg::job_t rd_job
);
	import pcgbr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_full = (count_q != CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_job = entry_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/pcgbr_back.sv
// back end: lcg stepper on one shared 32x32 multiplier, bit-serial modulo unit
// and the sequencer for reseed, raw and bounded draws; depends on pcgbr_pkg
module pcgbr_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_valid,
	input  pcgbr_pkg::job_t              job,
	output logic                         job_pop,
	input  logic [pcgbr_pkg::WORD_W-1:0] seed,
	input  logic [pcgbr_pkg::WORD_W-1:0] stream,
	output logic [pcgbr_pkg::WORD_W-1:0] m_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready
);
	import pcgbr_pkg::*;

	localparam int DIV_CNT_W = $clog2(WORD_W + 1);

	back_st_t st_q, st_d;
	logic [WORD_W-1:0] lcg_q, inc_q, acc_q;
	logic [1:0] mul_cnt_q;
	kind_t kind_q;
	logic [WORD_W-1:0] lower_q, span_q, thr_q, rem_q, dvd_q, result_q;
	logic [HALF_W-1:0] lo_half_q;
	logic half_q, phase_q, div_mod_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic [HALF_W-1:0] mul_a, mul_b, word;
	logic [WORD_W-1:0] pp, acc_n, v64;
	logic [WORD_W:0] div_t, div_r;
	logic [WORD_W-1:0] rem_n;
	logic draw_done, div_done, redraw32, redraw64;

	assign word = permute(lcg_q);
	assign v64 = {word, lo_half_q};

	// low 64 bits of state * mult + inc, three partial products
	always_comb begin
		mul_a = lcg_q[HALF_W-1:0];
		mul_b = LCG_MULT[HALF_W-1:0];
		unique case (mul_cnt_q)
			2'd1: mul_b = LCG_MULT[WORD_W-1:HALF_W];
			2'd2: mul_a = lcg_q[WORD_W-1:HALF_W];
			default: ;
		endcase
		pp = mul_a * mul_b;
		if (mul_cnt_q == 2'd0) begin
			acc_n = pp + inc_q;
		end else begin
			acc_n = acc_q + {pp[HALF_W-1:0], {HALF_W{1'b0}}};
		end
	end

	// restoring remainder step
	assign div_t = {rem_q, dvd_q[WORD_W-1]};
	assign div_r = (div_t >= {1'b0, span_q}) ? div_t - {1'b0, span_q} : div_t;
	assign rem_n = div_r[WORD_W-1:0];

	assign draw_done = (st_q == S_LCG) && (mul_cnt_q == 2'd2);
	assign div_done = (st_q == S_DIV) && (div_cnt_q == DIV_CNT_W'(1));
	assign redraw32 = ({{HALF_W{1'b0}}, word} < thr_q);
	assign redraw64 = (v64 < thr_q);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: begin
				if (job_valid) begin
					if ((job.kind == K_RANGE32 || job.kind == K_RANGE64)) begin
						st_d = (job.span == '0) ? S_OUT : S_DIV;
					end else begin
						st_d = S_LCG;
					end
				end
			end
			S_LCG: begin
				if (mul_cnt_q == 2'd2) begin
					unique case (kind_q)
						K_RESEED: st_d = phase_q ? S_IDLE : S_LCG;
						K_RAW32: st_d = S_OUT;
						K_RAW64: st_d = half_q ? S_OUT : S_LCG;
						K_RANGE32: st_d = redraw32 ? S_LCG : S_DIV;
						K_RANGE64: st_d = (!half_q || redraw64) ? S_LCG : S_DIV;
						default: st_d = S_IDLE;
					endcase
				end
			end
			S_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(1)) begin
					st_d = div_mod_q ? S_OUT : S_LCG;
				end
			end
			S_OUT: begin
				if (m_tready) begin
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	assign job_pop = (st_q == S_IDLE) && job_valid;
	assign m_tvalid = (st_q == S_OUT);
	assign m_tdata = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			lcg_q <= LCG_STATE_RST;
			inc_q <= LCG_INC_RST;
			mul_cnt_q <= '0;
			div_cnt_q <= '0;
			half_q <= 1'b0;
			phase_q <= 1'b0;
			div_mod_q <= 1'b0;
			kind_q <= K_RESEED;
		end else begin
			st_q <= st_d;
			if (st_q == S_LCG) begin
				mul_cnt_q <= (mul_cnt_q == 2'd2) ? 2'd0 : mul_cnt_q + 2'd1;
			end
			if (job_pop) begin
				kind_q <= job.kind;
				half_q <= 1'b0;
				phase_q <= 1'b0;
				mul_cnt_q <= '0;
				if (job.kind == K_RESEED) begin
					lcg_q <= '0;
					inc_q <= {stream[WORD_W-2:0], 1'b1};
				end
				div_mod_q <= 1'b0;
				div_cnt_q <= (job.kind == K_RANGE32) ? DIV_CNT_W'(HALF_W)
					: DIV_CNT_W'(WORD_W);
			end
			if (draw_done) begin
				if (kind_q == K_RESEED && !phase_q) begin
					lcg_q <= acc_n + seed;
					phase_q <= 1'b1;
				end else begin
					lcg_q <= acc_n;
				end
				if (kind_q == K_RAW64 || kind_q == K_RANGE64) begin
					half_q <= !half_q;
				end
				if ((kind_q == K_RANGE32 && !redraw32)
						|| (kind_q == K_RANGE64 && half_q && !redraw64)) begin
					div_mod_q <= 1'b1;
					div_cnt_q <= (kind_q == K_RANGE32) ? DIV_CNT_W'(HALF_W)
						: DIV_CNT_W'(WORD_W);
				end
			end
			if (st_q == S_DIV) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_LCG) begin
			acc_q <= acc_n;
		end
		if (job_pop) begin
			lower_q <= job.lower;
			span_q <= job.span;
			rem_q <= '0;
			if (job.kind == K_RANGE32) begin
				dvd_q <= {HALF_W'(0) - job.span[HALF_W-1:0], {HALF_W{1'b0}}};
				result_q <= {{HALF_W{1'b0}}, job.lower[HALF_W-1:0]};
			end else begin
				dvd_q <= WORD_W'(0) - job.span;
				result_q <= job.lower;
			end
		end
		if (draw_done) begin
			lo_half_q <= word;
			if (kind_q == K_RAW32) begin
				result_q <= {{HALF_W{1'b0}}, word};
			end else if (kind_q == K_RAW64) begin
				result_q <= v64;
			end
			rem_q <= '0;
			if (kind_q == K_RANGE32) begin
				dvd_q <= {word, {HALF_W{1'b0}}};
			end else begin
				dvd_q <= v64;
			end
		end
		if (st_q == S_DIV) begin
			rem_q <= rem_n;
			dvd_q <= dvd_q << 1;
		end
		if (div_done) begin
			if (!div_mod_q) begin
				thr_q <= rem_n;
			end else if (kind_q == K_RANGE32) begin
				result_q <= {{HALF_W{1'b0}}, lower_q[HALF_W-1:0] + rem_n[HALF_W-1:0]};
			end else begin
				result_q <= lower_q + rem_n;
			end
		end
	end

endmodule
